/* rtl/core/assert_macros.svh */
// Assertion macros shared by the relay's RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define DCFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define DCFR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `DCFR_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

/* rtl/core/dcfr_pkg.sv */
// Types and constants of the daisy chain frame relay.
package dcfr_pkg;

    // Buffer geometry
    localparam int BUF_BYTES   = 512;
    localparam int HDR_BYTES   = 8;
    localparam int STORE_DEPTH = 2 * BUF_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int OFF_W       = $clog2(BUF_BYTES + 1);
    localparam int HDR_IDX_W   = $clog2(HDR_BYTES);

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int QPTR_W   = $clog2(RQ_DEPTH);
    localparam int CNT_W    = $clog2(RQ_DEPTH + 1);

    // Saturation limits
    localparam logic [7:0]  TEMPO_MAX   = 8'hff;
    localparam logic [7:0]  TEMPO_RESET = 8'h80;
    localparam logic [15:0] MS_MAX      = 16'hffff;
    localparam logic [15:0] SILENCE_RESET = 16'd5;

    // Configuration port
    localparam int CFG_DATA_W = 32;

    typedef enum logic [0:0] {
        CFG_NODE_ID       = 1'b0,
        CFG_SILENCE_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_RX_WORD  = 2'd0,
        OP_TX_SLOT  = 2'd1,
        OP_MS_TICK  = 2'd2,
        OP_CONTROLS = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [8:0]  rx_word;
        logic [15:0] knob_level;
        logic        button_up;
        logic        button_down;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_frame_start;
    } t_out_item;

    // Transmit slot descriptor, front to back
    typedef struct packed {
        logic       from_header;
        logic [7:0] hdr_byte;
        logic       frame_start;
    } t_slot;

    // Payload store access, front to memory
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

endpackage

/* rtl/core/dcfr_ram.sv */
// Generic single-port RAM with registered read.
module dcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: write or registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dcfr_front.sv */
// Front end: decodes each beat, keeps buffer and header state, issues store accesses.
`include "assert_macros.svh"

module dcfr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  dcfr_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [dcfr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  dcfr_pkg::t_in_item                  i_item,
    output dcfr_pkg::t_mem_req                  o_mem_req,
    output logic                                o_slot_valid,
    output dcfr_pkg::t_slot                     o_slot
);

    localparam int OFF_W  = dcfr_pkg::OFF_W;
    localparam int ADDR_W = dcfr_pkg::ADDR_W;
    localparam int HIW    = dcfr_pkg::HDR_IDX_W;

    localparam logic [OFF_W-1:0]  HDR_OFF  = OFF_W'(dcfr_pkg::HDR_BYTES);
    localparam logic [OFF_W-1:0]  BUF_OFF  = OFF_W'(dcfr_pkg::BUF_BYTES);
    localparam logic [OFF_W-1:0]  LEN_MASK = ~OFF_W'(dcfr_pkg::HDR_BYTES - 1);
    localparam logic [ADDR_W-1:0] BUF_BASE = ADDR_W'(dcfr_pkg::BUF_BYTES);

    // Configuration registers
    logic [31:0]      r_node_id, n_node_id;
    logic [15:0]      r_silence, n_silence;
    // Buffer bookkeeping
    logic [OFF_W-1:0] r_len_a, n_len_a;
    logic [OFF_W-1:0] r_len_b, n_len_b;
    logic             r_send_sel, n_send_sel;
    logic             r_fill_sel, n_fill_sel;
    logic [OFF_W-1:0] r_send_off, n_send_off;
    logic [OFF_W-1:0] r_fill_off, n_fill_off;
    logic [15:0]      r_ms, n_ms;
    // Header fields
    logic [7:0]       r_tempo, n_tempo;
    logic [15:0]      r_intensity, n_intensity;

    logic [OFF_W-1:0] fo;
    logic             fs;
    logic [OFF_W:0]   send_next;
    logic [OFF_W-1:0] len_cur;
    logic [63:0]      header;

    assign header  = {8'h00, r_tempo, r_intensity, r_node_id};
    assign len_cur = r_send_sel ? r_len_b : r_len_a;

    // Next-state logic for configuration and accepted beats
    always_comb begin
        n_node_id    = r_node_id;
        n_silence    = r_silence;
        n_len_a      = r_len_a;
        n_len_b      = r_len_b;
        n_send_sel   = r_send_sel;
        n_fill_sel   = r_fill_sel;
        n_send_off   = r_send_off;
        n_fill_off   = r_fill_off;
        n_ms         = r_ms;
        n_tempo      = r_tempo;
        n_intensity  = r_intensity;
        o_mem_req    = '0;
        o_slot_valid = 1'b0;
        o_slot       = '0;
        fo           = r_fill_off;
        fs           = r_fill_sel;
        send_next    = {1'b0, r_send_off} + (OFF_W+1)'(1);

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dcfr_pkg::CFG_NODE_ID:       n_node_id = i_cfg_data[31:0];
                dcfr_pkg::CFG_SILENCE_LIMIT: n_silence = i_cfg_data[15:0];
                default:                     n_node_id = r_node_id;
            endcase
        end

        if (i_accept) begin
            unique case (i_item.op)
                dcfr_pkg::OP_RX_WORD: begin
                    // Frame start closes the fill buffer and swaps
                    if (i_item.rx_word[8]) begin
                        if (fs) begin
                            n_len_b = fo & LEN_MASK;
                        end else begin
                            n_len_a = fo & LEN_MASK;
                        end
                        fo   = HDR_OFF;
                        fs   = ~fs;
                        n_ms = '0;
                    end
                    if (fo < BUF_OFF) begin
                        o_mem_req.en    = 1'b1;
                        o_mem_req.we    = 1'b1;
                        o_mem_req.addr  = fs ? ADDR_W'(fo) + BUF_BASE : ADDR_W'(fo);
                        o_mem_req.wdata = i_item.rx_word[7:0];
                        fo              = fo + OFF_W'(1);
                    end
                    n_fill_off = fo;
                    n_fill_sel = fs;
                end
                dcfr_pkg::OP_TX_SLOT: begin
                    // Header bytes come from live registers, payload from the store
                    o_slot_valid         = 1'b1;
                    o_slot.from_header   = r_send_off < HDR_OFF;
                    o_slot.hdr_byte      = header[r_send_off[HIW-1:0]*8 +: 8];
                    o_slot.frame_start   = r_send_off == '0;
                    o_mem_req.en         = r_send_off >= HDR_OFF;
                    o_mem_req.addr       = r_send_sel ? ADDR_W'(r_send_off) + BUF_BASE
                                                      : ADDR_W'(r_send_off);
                    if (send_next >= {1'b0, len_cur}) begin
                        n_send_off = '0;
                        if (r_send_sel == r_fill_sel) begin
                            n_send_sel = ~r_send_sel;
                        end
                        if (r_ms > r_silence) begin
                            n_len_a = HDR_OFF;
                            n_len_b = HDR_OFF;
                        end
                    end else begin
                        n_send_off = send_next[OFF_W-1:0];
                    end
                end
                dcfr_pkg::OP_MS_TICK: begin
                    if (r_ms != dcfr_pkg::MS_MAX) begin
                        n_ms = r_ms + 16'd1;
                    end
                end
                dcfr_pkg::OP_CONTROLS: begin
                    if (i_item.button_up) begin
                        if (r_tempo != dcfr_pkg::TEMPO_MAX) begin
                            n_tempo = r_tempo + 8'd1;
                        end
                    end else if (i_item.button_down) begin
                        if (r_tempo != 8'd0) begin
                            n_tempo = r_tempo - 8'd1;
                        end
                    end
                    n_intensity = i_item.knob_level;
                end
                default: n_ms = r_ms;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= '0;
            r_silence   <= dcfr_pkg::SILENCE_RESET;
            r_len_a     <= HDR_OFF;
            r_len_b     <= HDR_OFF;
            r_send_sel  <= 1'b0;
            r_fill_sel  <= 1'b1;
            r_send_off  <= '0;
            r_fill_off  <= HDR_OFF;
            r_ms        <= '0;
            r_tempo     <= dcfr_pkg::TEMPO_RESET;
            r_intensity <= '0;
        end else begin
            r_node_id   <= n_node_id;
            r_silence   <= n_silence;
            r_len_a     <= n_len_a;
            r_len_b     <= n_len_b;
            r_send_sel  <= n_send_sel;
            r_fill_sel  <= n_fill_sel;
            r_send_off  <= n_send_off;
            r_fill_off  <= n_fill_off;
            r_ms        <= n_ms;
            r_tempo     <= n_tempo;
            r_intensity <= n_intensity;
        end
    end

    // Checks
    `DCFR_ASSERT(a_fill_range, i_clk, i_rst_n, (r_fill_off >= HDR_OFF) && (r_fill_off <= BUF_OFF), "fill offset out of range")
    `DCFR_ASSERT(a_len_aligned, i_clk, i_rst_n, (r_len_a[HIW-1:0] == '0) && (r_len_b[HIW-1:0] == '0) && (r_len_a >= HDR_OFF) && (r_len_b >= HDR_OFF), "frame length not header aligned")
    `DCFR_ASSERT(a_swap_on_start, i_clk, i_rst_n, (i_accept && (i_item.op == dcfr_pkg::OP_RX_WORD) && i_item.rx_word[8]) |=> (r_fill_sel != $past(r_fill_sel)), "frame start did not swap fill buffer")

endmodule

/* rtl/core/dcfr_back.sv */
// Back end: joins store read data with slot descriptors and queues result beats.
`include "assert_macros.svh"

module dcfr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_slot_valid,
    input  dcfr_pkg::t_slot       i_slot,
    input  logic [7:0]            i_mem_rdata,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic                  o_full,
    output dcfr_pkg::t_out_item   o_result
);

    localparam int DEPTH  = dcfr_pkg::RQ_DEPTH;
    localparam int QPTR_W = dcfr_pkg::QPTR_W;
    localparam int CNT_W  = dcfr_pkg::CNT_W;

    logic                  r_p1_valid;
    dcfr_pkg::t_slot       r_p1_slot;
    dcfr_pkg::t_out_item   r_q [DEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]      r_count, n_count;
    dcfr_pkg::t_out_item   p1_item;
    logic                  pop_ok;
    logic [CNT_W:0]        pending;

    // Byte select once the store read has landed
    assign p1_item.out_byte        = r_p1_slot.from_header ? r_p1_slot.hdr_byte : i_mem_rdata;
    assign p1_item.out_frame_start = r_p1_slot.frame_start;

    assign pop_ok  = i_pop && (r_count != '0);
    assign o_empty = r_count == '0;
    assign o_result = r_q[r_rd_ptr];

    // Room is reserved for the beat still in the read stage
    assign pending = {1'b0, r_count} + (CNT_W+1)'(r_p1_valid);
    assign o_full  = pending >= (CNT_W+1)'(DEPTH);

    // Queue pointers and occupancy
    always_comb begin
        n_wr_ptr = r_p1_valid ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(r_p1_valid) - CNT_W'(pop_ok);
    end

    // Read stage and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_p1_valid <= i_slot_valid;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_count    <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p1_slot <= i_slot;
        if (r_p1_valid) begin
            r_q[r_wr_ptr] <= p1_item;
        end
    end

    // Checks
    `DCFR_ASSERT(a_room_for_p1, i_clk, i_rst_n, r_p1_valid |-> (r_count < CNT_W'(DEPTH)), "read stage has no queue room")
    `DCFR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "result queue overfilled")
    `DCFR_ASSERT(a_slot_lands, i_clk, i_rst_n, i_slot_valid |=> r_p1_valid, "slot lost before read stage")

endmodule

/* rtl/core/daisy_chain_frame_relay.sv */
// Daisy chain frame relay node, top level.
// One input beat is taken per clock cycle of any op while full is low. A transmit
// slot beat reads the payload store (or the live header registers for bytes 0..7).
// Its result goes to the result ports through the result queue: the store read
// and the slot descriptor are registered at the accepting edge, and the join
// stage writes the result queue at the next one.
// The result queue holds four beats;
// full rises once four results are queued or in flight, so with pop held high
// the block keeps taking one beat every cycle. Received words, ticks and control
// updates finish in the cycle they are taken and give no result. The payload
// store powers up unknown and is not swept after reset; payload bytes are only
// sent after a received frame has written them. Configuration is always ready
// outside reset.
module daisy_chain_frame_relay (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  dcfr_pkg::t_in_item                i_item,
    output logic                              empty,
    input  logic                              pop,
    output dcfr_pkg::t_out_item               o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  dcfr_pkg::t_cfg_idx                i_cfg_index,
    input  logic [dcfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                accept;
    logic                back_full;
    dcfr_pkg::t_mem_req  mem_req;
    logic [7:0]          mem_rdata;
    logic                slot_valid;
    dcfr_pkg::t_slot     slot;

    assign full        = back_full || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = push && !full;

    // Decode and state update
    dcfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_item       (i_item),
        .o_mem_req    (mem_req),
        .o_slot_valid (slot_valid),
        .o_slot       (slot)
    );

    // Two payload buffers in one store
    dcfr_ram #(
        .WIDTH (8),
        .DEPTH (dcfr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_req.en),
        .i_we    (mem_req.we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

    // Result join and queue
    dcfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_valid (slot_valid),
        .i_slot       (slot),
        .i_mem_rdata  (mem_rdata),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_full       (back_full),
        .o_result     (o_result)
    );

endmodule

/* verif/daisy_chain_frame_relay_test.sv */
// Self-checking testbench for the daisy chain frame relay: queued stimulus, predictor, checker.
module daisy_chain_frame_relay_test;
    timeunit 1ns;
    timeprecision 1ps;

    // DUT ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    dcfr_pkg::t_in_item              i_item = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    dcfr_pkg::t_out_item             o_result;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    dcfr_pkg::t_cfg_idx              i_cfg_index = dcfr_pkg::CFG_NODE_ID;
    logic [dcfr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Stimulus and expectations
    dcfr_pkg::t_in_item  pending_items[$];
    dcfr_pkg::t_out_item tx_bytes_due[$];
    int                  sender_gap_pct = 12;
    int                  receiver_gap_pct = 61;
    int                  fail_count = 0;

    // Long receiver hold-off
    int unsigned pop_hold_left = 0;
    logic        hold_kick = 1'b0;

    // Captured result beat, checked on the falling edge
    logic                beat_taken = 1'b0;
    dcfr_pkg::t_out_item beat_seen;
    dcfr_pkg::t_out_item byte_due;

    // Mirror of the node state
    logic [7:0]                payload_mem [0:dcfr_pkg::STORE_DEPTH-1];
    logic [dcfr_pkg::OFF_W-1:0] frame_len [2];
    logic                      send_sel;
    logic                      fill_sel;
    logic [dcfr_pkg::OFF_W-1:0] send_off;
    logic [dcfr_pkg::OFF_W-1:0] fill_off;
    logic [15:0]               ms_quiet;
    logic [7:0]                tempo;
    logic [15:0]               intensity;
    logic [31:0]               node_id_val;
    logic [15:0]               silence_val;

    daisy_chain_frame_relay u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Advance the mirrored node by one accepted beat; a transmit slot queues its byte
    task automatic step_relay_state(input dcfr_pkg::t_in_item it);
        dcfr_pkg::t_out_item res;
        logic [7:0] b;
        case (it.op)
            dcfr_pkg::OP_RX_WORD: begin
                // frame start closes the fill buffer and swaps
                if (it.rx_word[8]) begin
                    frame_len[fill_sel] = fill_off &
                        ~(dcfr_pkg::OFF_W'(dcfr_pkg::HDR_BYTES - 1));
                    fill_off = dcfr_pkg::OFF_W'(dcfr_pkg::HDR_BYTES);
                    fill_sel = ~fill_sel;
                    ms_quiet = '0;
                end
                // full buffer drops the byte
                if (fill_off < dcfr_pkg::BUF_BYTES) begin
                    payload_mem[{fill_sel, fill_off[dcfr_pkg::ADDR_W-2:0]}] = it.rx_word[7:0];
                    fill_off = fill_off + 1'b1;
                end
            end
            dcfr_pkg::OP_TX_SLOT: begin
                if (send_off < dcfr_pkg::HDR_BYTES) begin
                    case (send_off[2:0])
                        3'd0:    b = node_id_val[7:0];
                        3'd1:    b = node_id_val[15:8];
                        3'd2:    b = node_id_val[23:16];
                        3'd3:    b = node_id_val[31:24];
                        3'd4:    b = intensity[7:0];
                        3'd5:    b = intensity[15:8];
                        3'd6:    b = tempo;
                        default: b = 8'h00;
                    endcase
                end else begin
                    b = payload_mem[{send_sel, send_off[dcfr_pkg::ADDR_W-2:0]}];
                end
                res.out_byte = b;
                res.out_frame_start = (send_off == 0);
                tx_bytes_due.push_back(res);
                send_off = send_off + 1'b1;
                // end of frame: follow the filler, cut lengths after silence
                if (send_off >= frame_len[send_sel]) begin
                    send_off = '0;
                    if (send_sel == fill_sel) send_sel = ~send_sel;
                    if (ms_quiet > silence_val) begin
                        frame_len[0] = dcfr_pkg::OFF_W'(dcfr_pkg::HDR_BYTES);
                        frame_len[1] = dcfr_pkg::OFF_W'(dcfr_pkg::HDR_BYTES);
                    end
                end
            end
            dcfr_pkg::OP_MS_TICK: begin
                if (ms_quiet != dcfr_pkg::MS_MAX) ms_quiet = ms_quiet + 1'b1;
            end
            default: begin
                if (it.button_up) begin
                    if (tempo != dcfr_pkg::TEMPO_MAX) tempo = tempo + 1'b1;
                end else if (it.button_down) begin
                    if (tempo != 8'h00) tempo = tempo - 1'b1;
                end
                intensity = it.knob_level;
            end
        endcase
    endtask

    // Driver: predict on acceptance, then offer the next beat or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) step_relay_state(i_item);
            if (!(push && full)) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    push   <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter
    always @(posedge i_clk) begin
        if (pop_hold_left != 0) pop_hold_left <= pop_hold_left - 1;
        else if (hold_kick) pop_hold_left <= 64;
    end

    // Monitor: capture each popped beat, drive pop
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop        <= 1'b0;
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= pop && !empty;
            beat_seen  <= o_result;
            pop        <= (pop_hold_left == 0) && ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    // Compare against the oldest expected byte
    always @(negedge i_clk) begin
        if (beat_taken) begin
            if (tx_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, byte %02h", beat_seen.out_byte));
            end else begin
                byte_due = tx_bytes_due.pop_front();
                if (beat_seen.out_byte !== byte_due.out_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                        beat_seen.out_byte, byte_due.out_byte));
                if (beat_seen.out_frame_start !== byte_due.out_frame_start)
                    report_mismatch($sformatf("out_frame_start %b, expected %b",
                        beat_seen.out_frame_start, byte_due.out_frame_start));
            end
        end
    end

    function automatic dcfr_pkg::t_in_item make_item(input dcfr_pkg::t_op op,
                                                     input logic [8:0] word,
                                                     input logic [15:0] knob,
                                                     input logic up,
                                                     input logic down);
        dcfr_pkg::t_in_item it;
        it.op          = op;
        it.rx_word     = word;
        it.knob_level  = knob;
        it.button_up   = up;
        it.button_down = down;
        return it;
    endfunction

    function automatic dcfr_pkg::t_in_item any_item(input dcfr_pkg::t_op op);
        return make_item(op, 9'($urandom_range(511)), 16'($urandom_range(65535)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic add_beats(input dcfr_pkg::t_op op, input int count);
        repeat (count) pending_items.push_back(any_item(op));
    endtask

    task automatic add_frame_word(input logic start);
        dcfr_pkg::t_in_item it;
        it = any_item(dcfr_pkg::OP_RX_WORD);
        it.rx_word[8] = start;
        pending_items.push_back(it);
    endtask

    // Tempo walk in one direction, with transmit slots now and then to expose the header
    task automatic queue_tempo_run(input logic raise, input int count);
        dcfr_pkg::t_in_item it;
        for (int k = 0; k < count; k++) begin
            it = any_item(dcfr_pkg::OP_CONTROLS);
            it.button_up = raise;
            if (!raise) it.button_down = 1'b1;
            pending_items.push_back(it);
            if (k % 50 == 49) add_beats(dcfr_pkg::OP_TX_SLOT, 4);
        end
    endtask

    // Mostly well-formed frames with interleaved slots, plus bursts and noise
    task automatic queue_random_traffic(input int budget);
        int added;
        int kind;
        int n;
        added = 0;
        while (added < budget) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 24);
                add_frame_word(1'b1);
                added++;
                repeat (n) begin
                    add_frame_word(1'b0);
                    added++;
                    if ($urandom_range(99) < 35) begin
                        add_beats(dcfr_pkg::OP_TX_SLOT, 1);
                        added++;
                    end else if ($urandom_range(99) < 8) begin
                        add_beats(dcfr_pkg::OP_MS_TICK, 1);
                        added++;
                    end
                end
            end else if (kind < 72) begin
                n = $urandom_range(1, 40);
                add_beats(dcfr_pkg::OP_TX_SLOT, n);
                added += n;
            end else if (kind < 82) begin
                n = $urandom_range(1, 12);
                add_beats(dcfr_pkg::OP_MS_TICK, n);
                added += n;
            end else if (kind < 92) begin
                n = $urandom_range(1, 3);
                add_beats(dcfr_pkg::OP_CONTROLS, n);
                added += n;
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) pending_items.push_back(any_item(dcfr_pkg::t_op'($urandom_range(3))));
                added += n;
            end
        end
    endtask

    task automatic write_cfg(input dcfr_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            dcfr_pkg::CFG_NODE_ID:       node_id_val = val;
            dcfr_pkg::CFG_SILENCE_LIMIT: silence_val = val[15:0];
            default:                     ;
        endcase
    endtask

    // Sender pause until every expected byte is back and the node is quiet
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || push || tx_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic kick_long_hold();
        @(negedge i_clk);
        hold_kick = 1'b1;
        @(negedge i_clk);
        hold_kick = 1'b0;
    endtask

    // Main sequence
    initial begin
        frame_len[0] = dcfr_pkg::OFF_W'(dcfr_pkg::HDR_BYTES);
        frame_len[1] = dcfr_pkg::OFF_W'(dcfr_pkg::HDR_BYTES);
        send_sel     = 1'b0;
        fill_sel     = 1'b1;
        send_off     = '0;
        fill_off     = dcfr_pkg::OFF_W'(dcfr_pkg::HDR_BYTES);
        ms_quiet     = '0;
        tempo        = dcfr_pkg::TEMPO_RESET;
        intensity    = '0;
        node_id_val  = '0;
        silence_val  = dcfr_pkg::SILENCE_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset header, button priority, two frames, buffer switch
        @(negedge i_clk);
        pending_items.push_back(make_item(dcfr_pkg::OP_TX_SLOT, 9'h1ff, 16'hffff, 1'b1, 1'b1));
        pending_items.push_back(make_item(dcfr_pkg::OP_CONTROLS, 9'h000, 16'hffff, 1'b1, 1'b1));
        pending_items.push_back(make_item(dcfr_pkg::OP_CONTROLS, 9'h1ff, 16'h8001, 1'b0, 1'b1));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h1ff, 16'h0000, 1'b0, 1'b0));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h0ff, 16'hffff, 1'b1, 1'b1));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h000, 16'h0000, 1'b0, 1'b0));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h055, 16'h5555, 1'b0, 1'b1));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h0aa, 16'haaaa, 1'b1, 1'b0));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h001, 16'h0001, 1'b0, 1'b0));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h080, 16'h8000, 1'b0, 1'b0));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h07f, 16'h7fff, 1'b0, 1'b0));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h100, 16'h0000, 1'b0, 1'b0));
        pending_items.push_back(make_item(dcfr_pkg::OP_RX_WORD, 9'h1aa, 16'h0000, 1'b0, 1'b0));
        repeat (16) begin
            pending_items.push_back(make_item(dcfr_pkg::OP_TX_SLOT, 9'h000, 16'h0000,
                                              1'b0, 1'b0));
        end
        wait_for_drain();

        // Phase 1: all-ones id, zero silence limit, tempo pushed to the top
        write_cfg(dcfr_pkg::CFG_NODE_ID, 32'hffff_ffff);
        write_cfg(dcfr_pkg::CFG_SILENCE_LIMIT, 32'd0);
        @(negedge i_clk);
        sender_gap_pct   = 12;
        receiver_gap_pct = 61;
        add_beats(dcfr_pkg::OP_TX_SLOT, 12);
        queue_random_traffic(30);
        queue_tempo_run(1'b1, 140);
        kick_long_hold();
        wait_for_drain();

        // Phase 2: random id, short silence limit, tempo pushed to the bottom
        write_cfg(dcfr_pkg::CFG_NODE_ID, $urandom());
        write_cfg(dcfr_pkg::CFG_SILENCE_LIMIT, $urandom_range(1, 40));
        @(negedge i_clk);
        sender_gap_pct   = 61;
        receiver_gap_pct = 12;
        add_beats(dcfr_pkg::OP_TX_SLOT, 8);
        queue_random_traffic(30);
        queue_tempo_run(1'b0, 265);
        kick_long_hold();
        wait_for_drain();

        // Phase 3: zero id, maximum silence limit, overflowing frame
        write_cfg(dcfr_pkg::CFG_NODE_ID, 32'd0);
        write_cfg(dcfr_pkg::CFG_SILENCE_LIMIT, 32'd65535);
        @(negedge i_clk);
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        add_beats(dcfr_pkg::OP_TX_SLOT, 8);
        queue_random_traffic(10);
        add_frame_word(1'b1);
        repeat (506) add_frame_word(1'b0);
        queue_random_traffic(10);
        add_beats(dcfr_pkg::OP_MS_TICK, 8);
        add_beats(dcfr_pkg::OP_TX_SLOT, 16);
        kick_long_hold();
        wait_for_drain();

        repeat (4) @(negedge i_clk);
        if (tx_bytes_due.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", tx_bytes_due.size()));
        if (fail_count == 0) begin
            $display("daisy_chain_frame_relay_test: PASS");
        end else begin
            $display("daisy_chain_frame_relay_test: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4ms;
        $display("daisy_chain_frame_relay_test: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/dcfr_pkg.sv
rtl/core/dcfr_ram.sv
rtl/core/dcfr_front.sv
rtl/core/dcfr_back.sv
rtl/core/daisy_chain_frame_relay.sv
verif/daisy_chain_frame_relay_test.sv
